// File: design/wsp_pkg.sv
// Shared types, constants and helpers for the wheel speed PID drive.
`default_nettype none

package wsp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int TURN_BITS = 16;

    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 34;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SUM_W   = PROD_W + 2;

    localparam logic signed [63:0] Q_ONE      = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] Q_STEP_FWD = (Q_ONE + 64'sd5) / 64'sd10;
    localparam logic signed [63:0] Q_STEP_REV = (Q_ONE + 64'sd10) / 64'sd20;
    localparam logic signed [63:0] Q_LAUNCH   = ((64'sd17 <<< FRAC_BITS) + 64'sd5) / 64'sd10;
    localparam logic signed [63:0] Q_INT_CAP  = 64'sd255 <<< FRAC_BITS;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    localparam logic [23:0] KP_RST          = 24'd273067;
    localparam logic [23:0] KI_DT_RST       = 24'd98304;
    localparam logic [23:0] KD_DT_RST       = 24'd524288;
    localparam logic [19:0] SPEED_DEG_RST   = 20'd9471;
    localparam logic [23:0] SPEED_LIMIT_RST = 24'd393216;
    localparam logic [7:0]  CEILING_RST     = 8'd128;
    localparam logic [7:0]  EASY_DRIVE_RST  = 8'd42;
    localparam logic [7:0]  FLOOR_RST       = 8'd28;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_ACCEL,
        OP_DIR,
        OP_EASY
    } t_op;

    typedef enum logic [1:0] {
        CMD_FWD,
        CMD_BACK,
        CMD_BRAKE,
        CMD_OTHER
    } t_cmd;

    typedef enum logic [2:0] {
        CFG_KP,
        CFG_KI_DT,
        CFG_KD_DT,
        CFG_SPEED_PER_DEGREE,
        CFG_SPEED_LIMIT,
        CFG_PID_CEILING,
        CFG_EASY_DRIVE,
        CFG_PID_FLOOR
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEG,
        S_RAW,
        S_PRES,
        S_ERR,
        S_MP,
        S_MI,
        S_MD,
        S_SUM,
        S_DRV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [1:0]         command;
        logic [8:0]         left_ang;
        logic signed [15:0] left_turns;
        logic [8:0]         right_ang;
        logic signed [15:0] right_turns;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         drive_value;
        logic signed [31:0] speed_now;
        logic               reverse_on;
        logic               easy_on;
    } t_out_item;

    typedef struct packed {
        logic [23:0] kp;
        logic [23:0] ki_dt;
        logic [23:0] kd_dt;
        logic [19:0] speed_per_degree;
        logic [23:0] speed_limit;
        logic [7:0]  pid_ceiling;
        logic [7:0]  easy_drive;
        logic [7:0]  pid_floor;
    } t_cfg;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > S32_MAX) begin
            return 32'sh7FFFFFFF;
        end else if (x < S32_MIN) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

endpackage

`default_nettype wire

// File: design/wsp_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none

module wsp_mul (
    input  wire logic                               i_clk,
    input  wire logic signed [wsp_pkg::MUL_A_W-1:0] i_a,
    input  wire logic signed [wsp_pkg::MUL_B_W-1:0] i_b,
    output logic signed [wsp_pkg::PROD_W-1:0]       o_prod
);
    import wsp_pkg::*;

    always_ff @(posedge i_clk) begin
        o_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

endmodule

`default_nettype wire

// File: design/wsp_drive.sv
// Shaping of the PID sum into the 8-bit motor drive value.
`default_nettype none

module wsp_drive (
    input  wire logic signed [wsp_pkg::SUM_W-1:0] i_sum,
    input  wire logic                             i_reverse,
    input  wire logic signed [31:0]               i_target,
    input  wire wsp_pkg::t_cfg                    i_cfg,
    output logic [7:0]                            o_drive
);
    import wsp_pkg::*;

    localparam int ADJW = FRAC_BITS + 16;
    localparam logic [ADJW-1:0] BIAS = ADJW'((64'd1 << FRAC_BITS) - 64'd1);

    logic [ADJW-1:0]    adj;
    logic signed [15:0] whole;
    logic signed [16:0] w17;
    logic signed [16:0] dir;
    logic [7:0]         clamped;
    logic [7:0]         lifted;
    logic [7:0]         capped;

    always_comb begin
        adj   = i_sum[ADJW-1:0] + (i_sum[SUM_W-1] ? BIAS : '0);
        whole = adj[ADJW-1:FRAC_BITS];
        w17   = {whole[15], whole};
        dir   = i_reverse ? -w17 : w17;
        if (dir < 17'sd0) begin
            clamped = 8'd0;
        end else if (dir > 17'sd255) begin
            clamped = 8'd255;
        end else begin
            clamped = dir[7:0];
        end
        lifted = (clamped != 8'd0 && clamped <= i_cfg.pid_floor) ? i_cfg.pid_floor : clamped;
        capped = (lifted > i_cfg.pid_ceiling) ? i_cfg.pid_ceiling : lifted;
        if (i_target > 32'sd0 && 64'(i_target) <= Q_LAUNCH) begin
            o_drive = i_cfg.pid_floor;
        end else begin
            o_drive = capped;
        end
    end

endmodule

`default_nettype wire

// File: design/wheel_speed_pid_drive.sv
// Top level of the wheel speed PID drive: sequencer, state and channels.
//
// Input channel: i_in_valid / o_in_stall carry one word of opcode, command
// and both wheel encoder readings. Opcode tick samples the encoders; accel,
// direction and easy-mode words update the target and modes and give no result.
// A command word finishes on acceptance and does not stall the input. A tick
// steps through DEG, RAW, PRES, ERR, MP, MI, MD, SUM, DRV and OUT in normal mode
// and DEG, RAW, PRES and OUT in easy mode; o_in_stall is high meanwhile, so no
// new word is taken until idle again. One shared multiplier forms the wheel speed
// and the P, I and D products in turn, each followed by its add/saturate step.
// Output channel: o_out_valid / i_out_stall carry drive value, present speed
// and mode flags. The result sits in an output register; a stalled result
// holds, and a finished tick waits in its last step until that register frees.
// Configuration: i_cfg_valid / o_cfg_ready write register i_cfg_index with
// i_cfg_data; ready is always high, writes belong to idle time.
// Reset (synchronous, active low) restores the register defaults, clears all
// control state and leaves the encoders unprimed: the first tick only stores
// the readings and gives no result.
`default_nettype none

module wheel_speed_pid_drive (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire wsp_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output wsp_pkg::t_out_item      o_out_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [23:0]        i_cfg_data
);
    import wsp_pkg::*;

    localparam int TSH = (TURN_BITS < 17) ? 17 - TURN_BITS : 0;
    localparam logic signed [33:0] STEP_FWD34 = 34'(Q_STEP_FWD);
    localparam logic signed [33:0] STEP_REV34 = 34'(Q_STEP_REV);
    localparam logic signed [33:0] ONE34      = 34'(Q_ONE);
    localparam logic signed [59:0] CAP60      = 60'(Q_INT_CAP);

    t_state             r_state, n_state;
    t_cfg               r_cfg, n_cfg;
    logic               r_reverse, n_reverse;
    logic               r_easy, n_easy;
    logic               r_primed, n_primed;
    logic signed [31:0] r_target, n_target;
    logic signed [31:0] r_present, n_present;
    logic signed [31:0] r_integral, n_integral;
    logic signed [31:0] r_last_err, n_last_err;
    logic [7:0]         r_held, n_held;
    logic [8:0]         r_prev_la, n_prev_la;
    logic signed [15:0] r_prev_lt, n_prev_lt;
    logic [8:0]         r_prev_ra, n_prev_ra;
    logic signed [15:0] r_prev_rt, n_prev_rt;
    logic               r_out_valid, n_out_valid;

    t_in_item                r_in, n_in;
    logic signed [27:0]      r_dsum, n_dsum;
    logic signed [31:0]      r_err, n_err;
    logic signed [PROD_W-1:0] r_p, n_p;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    t_out_item               r_out, n_out;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  r_prod;
    logic [7:0]                drive_out;
    logic                      in_accept;

    function automatic logic signed [26:0] wheel_deg(
        input logic [8:0]         ang,
        input logic signed [15:0] turns,
        input logic [8:0]         pang,
        input logic signed [15:0] pturns
    );
        logic signed [16:0] dturn;
        logic signed [16:0] wrapped;
        logic signed [26:0] turn_deg;
        logic signed [9:0]  dang;
        dturn    = {turns[15], turns} - {pturns[15], pturns};
        wrapped  = (dturn <<< TSH) >>> TSH;
        turn_deg = 27'(wrapped) * 27'sd360;
        dang     = $signed({1'b0, ang}) - $signed({1'b0, pang});
        return turn_deg + 27'(dang);
    endfunction

    wsp_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (r_prod)
    );

    wsp_drive u_drive (
        .i_sum     (r_sum),
        .i_reverse (r_reverse),
        .i_target  (r_target),
        .i_cfg     (r_cfg),
        .o_drive   (drive_out)
    );

    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cfg      <= '{kp: KP_RST, ki_dt: KI_DT_RST, kd_dt: KD_DT_RST,
                            speed_per_degree: SPEED_DEG_RST, speed_limit: SPEED_LIMIT_RST,
                            pid_ceiling: CEILING_RST, easy_drive: EASY_DRIVE_RST,
                            pid_floor: FLOOR_RST};
            r_reverse   <= 1'b0;
            r_easy      <= 1'b0;
            r_primed    <= 1'b0;
            r_target    <= '0;
            r_present   <= '0;
            r_integral  <= '0;
            r_last_err  <= '0;
            r_held      <= '0;
            r_prev_la   <= '0;
            r_prev_lt   <= '0;
            r_prev_ra   <= '0;
            r_prev_rt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cfg       <= n_cfg;
            r_reverse   <= n_reverse;
            r_easy      <= n_easy;
            r_primed    <= n_primed;
            r_target    <= n_target;
            r_present   <= n_present;
            r_integral  <= n_integral;
            r_last_err  <= n_last_err;
            r_held      <= n_held;
            r_prev_la   <= n_prev_la;
            r_prev_lt   <= n_prev_lt;
            r_prev_ra   <= n_prev_ra;
            r_prev_rt   <= n_prev_rt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_dsum <= n_dsum;
        r_err  <= n_err;
        r_p    <= n_p;
        r_sum  <= n_sum;
        r_out  <= n_out;
    end

    always_comb begin
        logic signed [33:0] t34;
        logic signed [33:0] lim34;
        logic signed [59:0] pres_sum;
        logic signed [32:0] diff33;
        logic signed [59:0] integ;
        logic               go;

        n_state     = r_state;
        n_cfg       = r_cfg;
        n_reverse   = r_reverse;
        n_easy      = r_easy;
        n_primed    = r_primed;
        n_target    = r_target;
        n_present   = r_present;
        n_integral  = r_integral;
        n_last_err  = r_last_err;
        n_held      = r_held;
        n_prev_la   = r_prev_la;
        n_prev_lt   = r_prev_lt;
        n_prev_ra   = r_prev_ra;
        n_prev_rt   = r_prev_rt;
        n_out_valid = r_out_valid;
        n_in        = r_in;
        n_dsum      = r_dsum;
        n_err       = r_err;
        n_p         = r_p;
        n_sum       = r_sum;
        n_out       = r_out;
        mul_a       = '0;
        mul_b       = '0;
        t34         = 34'(r_target);
        lim34       = {10'b0, r_cfg.speed_limit};
        pres_sum    = '0;
        diff33      = '0;
        integ       = '0;
        go          = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_KP:               n_cfg.kp = i_cfg_data;
                CFG_KI_DT:            n_cfg.ki_dt = i_cfg_data;
                CFG_KD_DT:            n_cfg.kd_dt = i_cfg_data;
                CFG_SPEED_PER_DEGREE: n_cfg.speed_per_degree = i_cfg_data[19:0];
                CFG_SPEED_LIMIT:      n_cfg.speed_limit = i_cfg_data;
                CFG_PID_CEILING:      n_cfg.pid_ceiling = i_cfg_data[7:0];
                CFG_EASY_DRIVE:       n_cfg.easy_drive = i_cfg_data[7:0];
                CFG_PID_FLOOR:        n_cfg.pid_floor = i_cfg_data[7:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    unique case (t_op'(i_in_data.opcode))
                        OP_TICK: begin
                            if (!r_primed) begin
                                n_prev_la = i_in_data.left_ang;
                                n_prev_lt = i_in_data.left_turns;
                                n_prev_ra = i_in_data.right_ang;
                                n_prev_rt = i_in_data.right_turns;
                                n_primed  = 1'b1;
                            end else begin
                                n_in    = i_in_data;
                                n_state = S_DEG;
                            end
                        end
                        OP_ACCEL: begin
                            if (r_easy) begin
                                go = r_reverse ? (i_in_data.command == CMD_BACK)
                                               : (i_in_data.command == CMD_FWD);
                                n_held = go ? r_cfg.easy_drive : 8'd0;
                            end else begin
                                unique case (t_cmd'(i_in_data.command))
                                    CMD_BRAKE: begin
                                        t34        = '0;
                                        n_integral = '0;
                                        n_held     = '0;
                                    end
                                    CMD_FWD: begin
                                        if (!r_reverse) begin
                                            t34 = t34 + STEP_FWD34;
                                            if (t34 > lim34) t34 = lim34;
                                        end else begin
                                            t34 = t34 + STEP_REV34;
                                            if (t34 > 34'sd0) t34 = '0;
                                        end
                                    end
                                    CMD_BACK: begin
                                        if (!r_reverse) begin
                                            t34 = t34 - STEP_FWD34;
                                            if (t34 < 34'sd0) t34 = '0;
                                        end else begin
                                            t34 = t34 - STEP_REV34;
                                            if (t34 < -lim34) t34 = -lim34;
                                        end
                                    end
                                    CMD_OTHER: ;
                                    default: ;
                                endcase
                                if (t34 > 34'sd0 && t34 <= ONE34) t34 = ONE34;
                                n_target = sat32(64'(t34));
                            end
                        end
                        OP_DIR: begin
                            n_reverse  = !r_reverse;
                            n_target   = '0;
                            n_integral = '0;
                            n_held     = '0;
                        end
                        OP_EASY: begin
                            n_easy     = !r_easy;
                            n_target   = '0;
                            n_integral = '0;
                            n_held     = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_DEG: begin
                n_dsum = 28'(wheel_deg(r_in.left_ang, r_in.left_turns, r_prev_la, r_prev_lt))
                       + 28'(wheel_deg(r_in.right_ang, r_in.right_turns, r_prev_ra, r_prev_rt));
                n_prev_la = r_in.left_ang;
                n_prev_lt = r_in.left_turns;
                n_prev_ra = r_in.right_ang;
                n_prev_rt = r_in.right_turns;
                n_state   = S_RAW;
            end
            S_RAW: begin
                mul_a   = $signed({5'b0, r_cfg.speed_per_degree});
                mul_b   = MUL_B_W'(r_dsum);
                n_state = S_PRES;
            end
            S_PRES: begin
                pres_sum  = (60'(r_present) <<< 1) + 60'(r_prod);
                n_present = sat32(64'(pres_sum >>> 2));
                n_state   = r_easy ? S_OUT : S_ERR;
            end
            S_ERR: begin
                diff33  = 33'(r_target) - 33'(r_present);
                n_err   = sat32(64'(diff33));
                n_state = S_MP;
            end
            S_MP: begin
                mul_a   = $signed({1'b0, r_cfg.kp});
                mul_b   = MUL_B_W'(r_err);
                n_state = S_MI;
            end
            S_MI: begin
                mul_a   = $signed({1'b0, r_cfg.ki_dt});
                mul_b   = MUL_B_W'(r_err);
                n_p     = r_prod >>> FRAC_BITS;
                n_state = S_MD;
            end
            S_MD: begin
                mul_a = $signed({1'b0, r_cfg.kd_dt});
                mul_b = MUL_B_W'(r_err) - MUL_B_W'(r_last_err);
                integ = 60'(r_integral) + 60'(r_prod >>> FRAC_BITS);
                if (integ > CAP60) integ = CAP60;
                n_integral = sat32(64'(integ));
                n_last_err = r_err;
                n_state    = S_SUM;
            end
            S_SUM: begin
                n_sum   = SUM_W'(r_p) + SUM_W'(r_integral) + SUM_W'(r_prod >>> FRAC_BITS);
                n_state = S_DRV;
            end
            S_DRV: begin
                n_held  = drive_out;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.drive_value = r_held;
                    n_out.speed_now   = r_present;
                    n_out.reverse_on  = r_reverse;
                    n_out.easy_on     = r_easy;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_out_from_final_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_OUT)
        else $error("result published outside the final step");

    a_integral_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        64'(r_integral) <= Q_INT_CAP)
        else $error("integral above its cap");

    a_command_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_data.opcode != OP_TICK) |=> !o_in_stall)
        else $error("command word did not finish in one cycle");

endmodule

`default_nettype wire
